// ----- design/multi_slot_event_timer_top_assert.svh -----
// ----------------------------------------------------------------------------
// multi_slot_event_timer_top_assert.svh
// assertion macros for the event timer checker, clocked on i_clk and
// disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef MULTI_SLOT_EVENT_TIMER_TOP_ASSERT_SVH
`define MULTI_SLOT_EVENT_TIMER_TOP_ASSERT_SVH

// same-cycle implication
`define MSET_ASSERT_NOW(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define MSET_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ----- design/mset_pkg.sv -----
// ----------------------------------------------------------------------------
// mset_pkg
// shared types, sizes and codes of the multi slot event timer
// ----------------------------------------------------------------------------
package mset_pkg;

    localparam int SLOT_COUNT = 16;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int TIME_W     = 31;
    localparam int EV_W       = 8;
    localparam int SLOT_OUT_W = 4;

    localparam logic [TIME_W-1:0] INT_MAX = 31'h7FFF_FFFF;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_ARM   = 2'd1;
    localparam logic [1:0] FUNC_DELAY = 2'd2;

    typedef struct packed {
        logic [1:0]        func;
        logic [TIME_W-1:0] first_timeout;
        logic [TIME_W-1:0] reload_timeout;
        logic [EV_W-1:0]   event_id;
        logic [TIME_W-1:0] delay_ticks;
    } t_in_item;

    typedef struct packed {
        logic                  fired;
        logic [EV_W-1:0]       fired_event;
        logic [SLOT_OUT_W-1:0] fired_slot;
        logic                  accepted;
        logic                  delay_done;
        logic [TIME_W-1:0]     tick_count;
        logic                  last;
    } t_out_item;

    // one entry of the slot table
    typedef struct packed {
        logic [TIME_W-1:0] rem;
        logic [TIME_W-1:0] rel;
        logic [EV_W-1:0]   ev;
    } t_slot_entry;

    typedef struct packed {
        logic load;
        logic tick_start;
        logic delay_load;
        logic arm_step;
        logic scan;
        logic final_push;
    } t_cmd;

    typedef struct packed {
        logic arm_done;
        logic scan_done;
        logic out_free;
    } t_status;

endpackage

// ----- design/mset_ctrl.sv -----
// ----------------------------------------------------------------------------
// mset_ctrl
// sequencer: takes an item, walks the slot table for arm or tick, then
// hands the closing result to the datapath
// ----------------------------------------------------------------------------
module mset_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_func,
    output logic              o_in_ready,
    input  mset_pkg::t_status i_status,
    output mset_pkg::t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ARM   = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FINAL = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    priority if (i_func == mset_pkg::FUNC_TICK) begin
                        o_cmd.tick_start = 1'b1;
                        n_state          = S_SCAN;
                    end else if (i_func == mset_pkg::FUNC_ARM) begin
                        n_state = S_ARM;
                    end else if (i_func == mset_pkg::FUNC_DELAY) begin
                        o_cmd.delay_load = 1'b1;
                        n_state          = S_FINAL;
                    end else begin
                        // unused code: just report current status
                        n_state = S_FINAL;
                    end
                end
            end
            S_ARM: begin
                o_cmd.arm_step = 1'b1;
                if (i_status.arm_done) begin
                    n_state = S_FINAL;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (i_status.out_free) begin
                    o_cmd.final_push = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/mset_dp.sv -----
// ----------------------------------------------------------------------------
// mset_dp
// slot table memory, busy bits, tick and delay counters, two-stage slot
// scan and the output register
// ----------------------------------------------------------------------------
module mset_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mset_pkg::t_cmd      i_cmd,
    input  mset_pkg::t_in_item  i_item,
    output mset_pkg::t_status   o_status,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output mset_pkg::t_out_item o_out_item
);

    localparam int SC = mset_pkg::SLOT_COUNT;
    localparam int IW = mset_pkg::IDX_W;
    localparam int CW = mset_pkg::CNT_W;
    localparam int TW = mset_pkg::TIME_W;
    localparam int EW = mset_pkg::EV_W;

    mset_pkg::t_slot_entry r_mem [SC];

    mset_pkg::t_in_item    r_item;
    mset_pkg::t_slot_entry r_rd;
    mset_pkg::t_out_item   r_out;
    mset_pkg::t_out_item   n_out;
    mset_pkg::t_slot_entry wr_data;

    logic [TW-1:0] r_tick;
    logic [TW-1:0] r_delay;
    logic [SC-1:0] r_busy;
    logic [CW-1:0] r_idx;
    logic          r_b_valid;
    logic [IW-1:0] r_b_idx;
    logic          r_b_busy;
    logic          r_acc;
    logic          r_pend_valid;
    logic [IW-1:0] r_pend_slot;
    logic [EW-1:0] r_pend_ev;
    logic          r_out_valid;

    logic [IW-1:0] idx;
    logic [TW-1:0] tick_inc;
    logic [TW-1:0] tick_next;
    logic          out_free;
    logic          b_hit;
    logic          scan_adv;
    logic          a_more;
    logic          arm_free;
    logic          arm_last;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic          push_mid;
    logic          push_any;

    assign idx       = r_idx[IW-1:0];
    assign tick_inc  = r_tick + TW'(1);
    assign tick_next = (tick_inc == mset_pkg::INT_MAX) ? '0 : tick_inc;
    assign out_free  = !r_out_valid || i_out_ready;
    // slot in the eval stage is active and counts down to zero
    assign b_hit     = r_b_valid && r_b_busy && (r_rd.rem == TW'(1));
    // hold the scan while a second hit has nowhere to go
    assign scan_adv  = i_cmd.scan && !(b_hit && r_pend_valid && !out_free);
    assign a_more    = (r_idx != CW'(SC));
    assign arm_free  = !r_busy[idx];
    assign arm_last  = (r_idx == CW'(SC - 1));
    assign push_mid  = scan_adv && b_hit && r_pend_valid;
    assign push_any  = push_mid || i_cmd.final_push;

    assign o_status.arm_done  = arm_free || arm_last;
    assign o_status.scan_done = !a_more && !r_b_valid;
    assign o_status.out_free  = out_free;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // single write port, shared by arm and scan write-back
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_b_idx;
        wr_data = r_rd;
        if (i_cmd.arm_step && arm_free) begin
            wr_en       = 1'b1;
            wr_addr     = idx;
            wr_data.rem = r_item.first_timeout;
            wr_data.rel = r_item.reload_timeout;
            wr_data.ev  = r_item.event_id;
        end else if (scan_adv && r_b_valid && r_b_busy) begin
            wr_en       = 1'b1;
            wr_data.rem = b_hit ? r_rd.rel : (r_rd.rem - TW'(1));
        end
    end

    always_comb begin
        n_out            = '0;
        n_out.delay_done = (r_delay == '0);
        n_out.tick_count = r_tick;
        if (push_mid) begin
            n_out.fired       = 1'b1;
            n_out.fired_event = r_pend_ev;
            n_out.fired_slot  = mset_pkg::SLOT_OUT_W'(r_pend_slot);
        end else begin
            n_out.last = 1'b1;
            if (r_pend_valid) begin
                n_out.fired       = 1'b1;
                n_out.fired_event = r_pend_ev;
                n_out.fired_slot  = mset_pkg::SLOT_OUT_W'(r_pend_slot);
            end else begin
                n_out.accepted = r_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (scan_adv && a_more) begin
            r_rd <= r_mem[idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (scan_adv && a_more) begin
            r_b_idx  <= idx;
            r_b_busy <= r_busy[idx];
        end
        if (scan_adv && b_hit) begin
            r_pend_slot <= r_b_idx;
            r_pend_ev   <= r_rd.ev;
        end
        if (push_any) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick       <= '0;
            r_delay      <= '0;
            r_busy       <= '0;
            r_idx        <= '0;
            r_b_valid    <= 1'b0;
            r_acc        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_idx        <= CW'(1);
                r_b_valid    <= 1'b0;
                r_acc        <= 1'b0;
                r_pend_valid <= 1'b0;
            end
            if (i_cmd.tick_start) begin
                r_tick <= tick_next;
                if (r_delay != '0) begin
                    r_delay <= r_delay - TW'(1);
                end
            end
            if (i_cmd.delay_load) begin
                r_delay <= i_item.delay_ticks;
            end
            if (i_cmd.arm_step) begin
                if (arm_free) begin
                    r_acc <= 1'b1;
                end else if (!arm_last) begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            if (scan_adv) begin
                r_b_valid <= a_more;
                if (a_more) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (b_hit) begin
                    r_pend_valid <= 1'b1;
                end
            end
            if (wr_en) begin
                r_busy[wr_addr] <= (wr_data.rem != '0);
            end
            if (push_any) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// ----- design/multi_slot_event_timer_top.sv -----
// ----------------------------------------------------------------------------
// multi_slot_event_timer_top
// table of periodic timer slots with a delay counter and a tick count
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_ready / i_in_data) takes one item:
//   tick, arm an event in lowest free slot 1..15, or load the delay counter.
//   output channel (o_out_valid / i_out_ready / o_out_data) returns the
//   results of that item; a tick gives one per expiring slot (one if none) in
//   ascending slot order, every other item gives one; last marks the final.
//   one item is in work at a time; o_in_ready is high only when idle.
//   a delay load or unused code goes straight to its result; an arm walks
//   the slots up to the lowest free one; a tick scans the whole slot table,
//   one table read and one write-back per cycle while the scan is not held.
//   a held result stalls the scan only when a further hit needs the output
//   register; the item is accepted while the last result still waits.
//   reset (synchronous, active low) frees every slot through the busy bits
//   and clears the tick and delay counters.
// ----------------------------------------------------------------------------
module multi_slot_event_timer_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mset_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mset_pkg::t_out_item o_out_data
);

    mset_pkg::t_cmd    cmd;
    mset_pkg::t_status status;

    mset_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_in_data.func),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mset_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_in_data),
        .o_status    (status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_data)
    );

endmodule

// ----- design/mset_chk.sv -----
// ----------------------------------------------------------------------------
// mset_chk
// port-level checks of the event timer result channel
// ----------------------------------------------------------------------------
`include "multi_slot_event_timer_top_assert.svh"

module mset_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input mset_pkg::t_out_item o_out_data
);

    `MSET_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "result changed while stalled")

    `MSET_ASSERT_NOW(a_idle_fields, o_out_valid && !o_out_data.fired, (o_out_data.fired_event == '0) && (o_out_data.fired_slot == '0), "non-fired result carries slot data")

    `MSET_ASSERT_NOW(a_fired_no_acc, o_out_valid && o_out_data.fired, !o_out_data.accepted, "fired result flagged as accepted")

    `MSET_ASSERT_NOW(a_tick_range, o_out_valid, o_out_data.tick_count != mset_pkg::INT_MAX, "tick count reached wrap value")

endmodule

bind multi_slot_event_timer_top mset_chk u_mset_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ----- test/multi_slot_event_timer_top_tb.sv -----
// ----------------------------------------------------------------------------
// multi_slot_event_timer_top_tb
// drives tick, arm, delay load and unused items into the event timer and
// compares every result item, field by field, with a predicted copy of the
// slot table, delay counter and tick count
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module multi_slot_event_timer_top_tb;

    localparam int SLOT_COUNT = mset_pkg::SLOT_COUNT;
    localparam int TIME_W     = mset_pkg::TIME_W;
    localparam int EV_W       = mset_pkg::EV_W;
    localparam int SLOT_OUT_W = mset_pkg::SLOT_OUT_W;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 500;
    localparam int CALM_FROM    = 420;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 300;

    // prediction of the slot table and the expected result items
    class timer_scoreboard;
        bit [TIME_W-1:0]     time_left [SLOT_COUNT];
        bit [TIME_W-1:0]     reload_val [SLOT_COUNT];
        bit [EV_W-1:0]       slot_ev [SLOT_COUNT];
        bit [TIME_W-1:0]     tick_cnt;
        bit [TIME_W-1:0]     delay_cnt;
        mset_pkg::t_out_item predicted_out[$];
        int                  errors;

        function void apply_item(mset_pkg::t_in_item it);
            mset_pkg::t_out_item r;
            bit [SLOT_COUNT-1:0] hit;
            int n;
            int k;
            r   = '0;
            hit = '0;
            case (it.func)
                mset_pkg::FUNC_TICK: begin
                    for (int s = 1; s < SLOT_COUNT; s++) begin
                        if (time_left[s] != 0) begin
                            time_left[s]--;
                            if (time_left[s] == 0) begin
                                hit[s] = 1'b1;
                                time_left[s] = reload_val[s];
                            end
                        end
                    end
                    if (delay_cnt != 0)
                        delay_cnt--;
                    tick_cnt = tick_cnt + 1'b1;
                    if (tick_cnt == mset_pkg::INT_MAX)
                        tick_cnt = '0;
                end
                mset_pkg::FUNC_ARM: begin
                    for (int s = 1; s < SLOT_COUNT; s++) begin
                        if (time_left[s] == 0) begin
                            time_left[s]  = it.first_timeout;
                            reload_val[s] = it.reload_timeout;
                            slot_ev[s]    = it.event_id;
                            r.accepted    = 1'b1;
                            break;
                        end
                    end
                end
                mset_pkg::FUNC_DELAY: begin
                    delay_cnt = it.delay_ticks;
                end
                default: ;
            endcase
            r.delay_done = (delay_cnt == 0);
            r.tick_count = tick_cnt;
            n = $countones(hit);
            if (n == 0) begin
                r.last = 1'b1;
                predicted_out.push_back(r);
            end else begin
                k = 0;
                for (int s = 1; s < SLOT_COUNT; s++) begin
                    if (hit[s]) begin
                        r.fired       = 1'b1;
                        r.fired_event = slot_ev[s];
                        r.fired_slot  = SLOT_OUT_W'(s);
                        r.last        = (k == n - 1);
                        predicted_out.push_back(r);
                        k++;
                    end
                end
            end
        endfunction

        function void cmp(string name, logic [31:0] want_v, logic [31:0] got_v);
            if (got_v !== want_v) begin
                $error("%s: expected %0d, got %0d", name, want_v, got_v);
                errors++;
            end
        endfunction

        function void check_report(mset_pkg::t_out_item got);
            mset_pkg::t_out_item want;
            if (predicted_out.size() == 0) begin
                $error("result item with nothing expected: %h", got);
                errors++;
                return;
            end
            want = predicted_out.pop_front();
            cmp("fired", want.fired, got.fired);
            cmp("fired_event", want.fired_event, got.fired_event);
            cmp("fired_slot", want.fired_slot, got.fired_slot);
            cmp("accepted", want.accepted, got.accepted);
            cmp("delay_done", want.delay_done, got.delay_done);
            cmp("tick_count", want.tick_count, got.tick_count);
            cmp("last", want.last, got.last);
        endfunction
    endclass

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    mset_pkg::t_in_item  in_data   = '0;
    logic                out_ready = 1'b0;
    logic                in_ready;
    logic                out_valid;
    mset_pkg::t_out_item out_data;

    timer_scoreboard book = new();

    bit quiet;
    bit hold_req;
    bit hold_taken;
    int hold_left;
    int stall_left;

    multi_slot_event_timer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #1 i_clk = ~i_clk;

    // receiver: check accepted results, then pick ready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready)
            book.check_report(out_data);
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
            out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic mset_pkg::t_in_item random_fields();
        mset_pkg::t_in_item it;
        it.func           = 2'($urandom());
        it.first_timeout  = TIME_W'($urandom());
        it.reload_timeout = TIME_W'($urandom());
        it.event_id       = EV_W'($urandom());
        it.delay_ticks    = TIME_W'($urandom());
        return it;
    endfunction

    task automatic send_item(input mset_pkg::t_in_item it);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (in_ready !== 1'b1);
        book.apply_item(it);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (book.predicted_out.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_simple(input logic [1:0] func, input logic [TIME_W-1:0] first,
                               input logic [TIME_W-1:0] rel, input logic [EV_W-1:0] ev,
                               input logic [TIME_W-1:0] dly);
        mset_pkg::t_in_item it;
        it = random_fields();
        it.func = func;
        if (func == mset_pkg::FUNC_ARM) begin
            it.first_timeout  = first;
            it.reload_timeout = rel;
            it.event_id       = ev;
        end
        if (func == mset_pkg::FUNC_DELAY)
            it.delay_ticks = dly;
        send_item(it);
    endtask

    initial begin
        mset_pkg::t_in_item it;
        int sel;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        send_simple(FUNC_UNUSED, '0, '0, '0, '0);
        send_simple(mset_pkg::FUNC_DELAY, '0, '0, '0, mset_pkg::INT_MAX);
        send_simple(mset_pkg::FUNC_TICK, '0, '0, '0, '0);
        send_simple(mset_pkg::FUNC_DELAY, '0, '0, '0, 31'd1);
        send_simple(mset_pkg::FUNC_TICK, '0, '0, '0, '0);
        send_simple(mset_pkg::FUNC_TICK, '0, '0, '0, '0);
        // zero first timeout: written but the slot stays free
        send_simple(mset_pkg::FUNC_ARM, '0, mset_pkg::INT_MAX, 8'hFF, '0);
        send_simple(mset_pkg::FUNC_ARM, mset_pkg::INT_MAX, mset_pkg::INT_MAX, 8'h00, '0);
        for (int k = 0; k < SLOT_COUNT - 2; k++)
            send_simple(mset_pkg::FUNC_ARM, TIME_W'(1 + k % 3), (k == 0) ? 31'd3 : 31'd0,
                        EV_W'(k * 17 + 1), '0);
        // table full, arm is refused
        send_simple(mset_pkg::FUNC_ARM, 31'd5, '0, 8'hA5, '0);
        repeat (3) send_simple(mset_pkg::FUNC_TICK, '0, '0, '0, '0);
        drain_results();

        // random part
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == CALM_FROM)
                quiet = 1'b1;
            if (i == HOLD_AT)
                hold_req = 1'b1;
            it  = random_fields();
            sel = $urandom_range(0, 99);
            if (sel < 50) begin
                it.func = mset_pkg::FUNC_TICK;
            end else if (sel < 85) begin
                it.func = mset_pkg::FUNC_ARM;
                it.first_timeout = ($urandom_range(0, 19) == 0) ? 31'd0
                                                                : TIME_W'($urandom_range(1, 10));
                it.reload_timeout = ($urandom_range(0, 39) == 0)
                                    ? TIME_W'($urandom_range(2, 12)) : 31'd0;
            end else if (sel < 95) begin
                it.func = mset_pkg::FUNC_DELAY;
                if ($urandom_range(0, 3) != 0)
                    it.delay_ticks = TIME_W'($urandom_range(0, 20));
            end else begin
                it.func = FUNC_UNUSED;
            end
            send_item(it);
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (book.errors == 0 && book.predicted_out.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
